[hdl/assert_macros.svh]
// assertion macros shared by the hash table rtl
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define OCH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition seen on one edge implies a consequence on the next edge
`define OCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/och_pkg.sv]
// operation and status codes of the ordered coalesced hash table
// no dependencies
package och_pkg;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int HASH_W   = 32;
    localparam int CURSOR_W = 8;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 9;

    localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SET    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_END      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MODIFIED = 3'd4;

endpackage

[hdl/och_ram.sv]
// generic single-port ram with registered read
// no dependencies
module och_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ordered_coalesced_hash_table.sv]
// ordered coalesced hash table: chained scatter hashing with in-table chains
// and an insertion-order doubly linked list; uses och_pkg, och_ram
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tuser: func; tdata: key, hash, value, cursor
//  m_axis   | out | m_axis_tvalid/tready    | tuser: status, was_inserted;
//           |     |                         | tdata: found_value, next_key, slot, count
//
// one transaction at a time, every slot record in one single-port ram
// lookup: walks the hash chain from the home slot, ready again once the result is registered
// insert adds a probe for a free slot and up to three list-link read-modify-writes
// delete relinks the order list after the lookup, plus a chain walk for a non-head slot
// synchronous active-low reset empties the table at once (valid flops)
// the result waits in an output register while m_axis_tready is low
`include "assert_macros.svh"

module ordered_coalesced_hash_table #(
    parameter int CAPACITY = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [167:0]  s_axis_tdata,  // key_word, key_hash, value_word, cursor_slot
    input  logic [2:0]    s_axis_tuser,  // func
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [151:0]  m_axis_tdata,  // found_value, next_key, result_slot, entry_count
    output logic [3:0]    m_axis_tuser   // status, was_inserted
);
    import och_pkg::*;

    localparam int IW  = $clog2(CAPACITY);
    localparam int LW  = IW + 1;
    localparam int LIM = 4 * CAPACITY + 64;
    localparam int NW  = $clog2(LIM + 1);
    localparam logic [LW-1:0] NO_LINK = LW'(CAPACITY);

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [HASH_W-1:0]  hash;
        logic [LW-1:0]      chain;
        logic [LW-1:0]      oprev;
        logic [LW-1:0]      onext;
    } t_rec;
    localparam int RW = $bits(t_rec);

    localparam logic [4:0] S_IDLE = 5'd0,  S_LOC0 = 5'd1,  S_LOC1 = 5'd2,  S_DISP = 5'd3,
                           S_NXC0 = 5'd4,  S_NXC1 = 5'd5,  S_NXG  = 5'd6,  S_NXR  = 5'd7,
                           S_INS  = 5'd8,  S_PRB  = 5'd9,  S_INSH = 5'd10, S_INSH2 = 5'd11,
                           S_INSN = 5'd12, S_AP0  = 5'd13, S_AP1  = 5'd14, S_RM0  = 5'd15,
                           S_RM1  = 5'd16, S_RD0  = 5'd17, S_RD1  = 5'd18, S_MV0  = 5'd19,
                           S_MV1  = 5'd20, S_ER0  = 5'd21, S_ER1  = 5'd22, S_ER2  = 5'd23,
                           S_ER3  = 5'd24, S_ERZ  = 5'd25, S_FIN  = 5'd26;

    // control
    logic [4:0]          r_state, n_state;
    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [LW-1:0]       r_head, n_head, r_tail, n_tail, r_count, n_count;
    logic                r_ovalid, n_ovalid;
    // payload
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [IW-1:0]       r_cur, n_cur, r_ci, n_ci, r_fidx, n_fidx, r_mdst, n_mdst;
    logic [IW-1:0]       r_wa, n_wa, r_hd, n_hd, r_fr, n_fr, r_idx, n_idx, r_clr, n_clr;
    logic                r_first, n_first, r_hit, n_hit, r_wsel, n_wsel, r_lin, n_lin;
    t_rec                r_rec, n_rec, r_mv, n_mv;
    logic [4:0]          r_ret, n_ret, r_mret, n_mret, r_xret, n_xret;
    logic [LW-1:0]       r_wv, n_wv, r_rs, n_rs, r_rr, n_rr;
    logic [31:0]         r_h, n_h, r_p, n_p;
    logic [NW-1:0]       r_n, n_n;
    logic [STATUS_W-1:0] r_st, n_st, r_ost, n_ost;
    logic [63:0]         r_found, n_found, r_nkey, n_nkey, r_ofound, n_ofound;
    logic [63:0]         r_onkey, n_onkey;
    logic [IW-1:0]       r_slot, n_slot;
    logic                r_ins, n_ins, r_oins, n_oins;
    logic [SLOT_W-1:0]   r_oslot, n_oslot;
    logic [COUNT_W-1:0]  r_ocnt, n_ocnt;

    logic                ram_we;
    logic [IW-1:0]       ram_addr;
    t_rec                ram_wd, rd, w;
    logic [RW-1:0]       ram_rd;
    logic [IW-1:0]       pi, hd;
    logic [31:0]         cur32;

    och_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wd),
        .o_rdata (ram_rd)
    );

    assign rd = t_rec'(ram_rd);

    always_comb begin
        n_state = r_state; n_valid = r_valid; n_head = r_head; n_tail = r_tail;
        n_count = r_count; n_ovalid = r_ovalid;
        n_func = r_func; n_key = r_key; n_hash = r_hash; n_val = r_val; n_cur = r_cur;
        n_ci = r_ci; n_fidx = r_fidx; n_mdst = r_mdst; n_wa = r_wa; n_hd = r_hd;
        n_fr = r_fr; n_idx = r_idx; n_clr = r_clr; n_first = r_first; n_hit = r_hit;
        n_wsel = r_wsel; n_lin = r_lin; n_rec = r_rec; n_mv = r_mv; n_ret = r_ret;
        n_mret = r_mret; n_xret = r_xret; n_wv = r_wv; n_rs = r_rs; n_rr = r_rr;
        n_h = r_h; n_p = r_p; n_n = r_n; n_st = r_st; n_found = r_found;
        n_nkey = r_nkey; n_slot = r_slot; n_ins = r_ins; n_ost = r_ost;
        n_ofound = r_ofound; n_onkey = r_onkey; n_oins = r_oins; n_oslot = r_oslot;
        n_ocnt = r_ocnt;
        ram_we = 1'b0; ram_addr = '0; ram_wd = '0; w = rd;
        hd = r_hash[IW-1:0];
        pi = r_lin ? IW'(r_hd + r_n[IW-1:0]) : r_h[IW-1:0];
        cur32 = 32'(s_axis_tdata[167:160]);

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func = s_axis_tuser;
                    n_key = s_axis_tdata[63:0];
                    n_hash = s_axis_tdata[95:64];
                    n_val = s_axis_tdata[159:96];
                    n_cur = cur32[IW-1:0];
                    n_st = ST_NOTFOUND; n_found = '0; n_nkey = '0; n_slot = '0; n_ins = 1'b0;
                    if (s_axis_tuser == FN_NEXT) begin
                        if (r_count == '0) begin
                            n_st = ST_END;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_NXC0;
                        end
                    end else if (s_axis_tuser == FN_LOOKUP || s_axis_tuser == FN_SET ||
                                 s_axis_tuser == FN_UPDATE || s_axis_tuser == FN_DELETE) begin
                        n_state = S_LOC0;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LOC0: begin
                if (r_count == '0 || !r_valid[hd]) begin
                    n_hit = 1'b0;
                    n_state = S_DISP;
                end else begin
                    ram_addr = hd; n_ci = hd; n_first = 1'b1;
                    n_state = S_LOC1;
                end
            end
            S_LOC1: begin
                // walk the chain one node per cycle
                if (r_first && rd.hash[IW-1:0] != r_ci) begin
                    n_hit = 1'b0; n_state = S_DISP;
                end else if (r_valid[r_ci] && rd.key == r_key) begin
                    n_hit = 1'b1; n_fidx = r_ci; n_rec = rd; n_state = S_DISP;
                end else if (rd.chain[IW]) begin
                    n_hit = 1'b0; n_state = S_DISP;
                end else begin
                    n_ci = rd.chain[IW-1:0]; ram_addr = rd.chain[IW-1:0]; n_first = 1'b0;
                end
            end
            S_DISP: begin
                n_state = S_FIN;
                case (r_func)
                    FN_LOOKUP: begin
                        if (r_hit) begin
                            n_st = ST_OK; n_found = r_rec.value; n_slot = r_fidx;
                        end
                    end
                    FN_SET, FN_UPDATE: begin
                        if (r_hit) begin
                            w = r_rec; w.value = r_val;
                            ram_we = 1'b1; ram_addr = r_fidx; ram_wd = w;
                            n_st = ST_OK; n_slot = r_fidx;
                        end else if (r_func == FN_SET) begin
                            if (r_count[IW]) begin
                                n_st = ST_FULL;
                            end else begin
                                n_state = S_INS;
                            end
                        end
                    end
                    FN_DELETE: begin
                        if (r_hit) begin
                            n_state = S_ER0;
                        end
                    end
                    FN_NEXT: begin
                        if (r_hit) begin
                            n_state = S_NXG;
                        end else begin
                            n_st = ST_MODIFIED;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_NXC0: begin
                ram_addr = r_cur; n_ci = r_cur; n_state = S_NXC1;
            end
            S_NXC1: begin
                if (r_valid[r_ci] && rd.key == r_key) begin
                    n_rec = rd; n_state = S_NXG;
                end else begin
                    n_state = S_LOC0;
                end
            end
            S_NXG: begin
                if (r_rec.onext[IW]) begin
                    n_st = ST_END; n_state = S_FIN;
                end else begin
                    ram_addr = r_rec.onext[IW-1:0]; n_state = S_NXR;
                end
            end
            S_NXR: begin
                n_st = ST_OK; n_nkey = rd.key; n_slot = r_rec.onext[IW-1:0];
                n_state = S_FIN;
            end
            S_INS: begin
                n_hd = hd;
                if (!r_valid[hd]) begin
                    ram_we = 1'b1; ram_addr = hd;
                    ram_wd = '{key: r_key, value: r_val, hash: r_hash, chain: NO_LINK,
                               oprev: r_tail, onext: NO_LINK};
                    n_idx = hd; n_state = S_AP0;
                end else begin
                    n_h = 32'(hd) + 32'd1; n_p = 32'(hd); n_n = '0; n_lin = 1'b0;
                    n_state = S_PRB;
                end
            end
            S_PRB: begin
                // scatter probe, then a linear sweep once the probe budget is spent
                if (!r_valid[pi]) begin
                    n_fr = pi; ram_addr = r_hd; n_state = S_INSH;
                end else if (!r_lin) begin
                    n_p = r_p >> 5;
                    n_h = (r_h << 2) + r_h + (r_p >> 5) + 32'd1;
                    if (r_n == NW'(LIM - 1)) begin
                        n_lin = 1'b1; n_n = '0;
                    end else begin
                        n_n = r_n + NW'(1);
                    end
                end else begin
                    n_n = r_n + NW'(1);
                end
            end
            S_INSH: begin
                n_mv = rd;
                if (rd.hash[IW-1:0] == r_hd) begin
                    ram_we = 1'b1; ram_addr = r_fr;
                    ram_wd = '{key: r_key, value: r_val, hash: r_hash, chain: rd.chain,
                               oprev: r_tail, onext: NO_LINK};
                    n_idx = r_fr; n_state = S_INSH2;
                end else begin
                    // home slot holds a foreign node: relink its chain, move it out
                    n_ci = rd.hash[IW-1:0]; n_rs = LW'(r_hd); n_rr = LW'(r_fr);
                    n_mret = S_MV0; n_xret = S_INSN; n_mdst = r_fr;
                    n_state = S_RD0;
                end
            end
            S_INSH2: begin
                w = r_mv; w.chain = LW'(r_fr);
                ram_we = 1'b1; ram_addr = r_hd; ram_wd = w;
                n_state = S_AP0;
            end
            S_INSN: begin
                ram_we = 1'b1; ram_addr = r_hd;
                ram_wd = '{key: r_key, value: r_val, hash: r_hash, chain: NO_LINK,
                           oprev: r_tail, onext: NO_LINK};
                n_idx = r_hd; n_state = S_AP0;
            end
            S_AP0: begin
                if (r_tail[IW]) begin
                    n_head = LW'(r_idx); n_state = S_AP1;
                end else begin
                    n_wa = r_tail[IW-1:0]; n_wsel = 1'b0; n_wv = LW'(r_idx);
                    n_ret = S_AP1; n_state = S_RM0;
                end
            end
            S_AP1: begin
                n_tail = LW'(r_idx); n_count = r_count + LW'(1); n_valid[r_idx] = 1'b1;
                n_st = ST_OK; n_slot = r_idx; n_ins = 1'b1; n_state = S_FIN;
            end
            S_RM0: begin
                ram_addr = r_wa; n_state = S_RM1;
            end
            S_RM1: begin
                w = rd;
                if (r_wsel) begin
                    w.oprev = r_wv;
                end else begin
                    w.onext = r_wv;
                end
                ram_we = 1'b1; ram_addr = r_wa; ram_wd = w;
                n_state = r_ret;
            end
            S_RD0: begin
                ram_addr = r_ci; n_state = S_RD1;
            end
            S_RD1: begin
                if (rd.chain == r_rs) begin
                    w = rd; w.chain = r_rr;
                    ram_we = 1'b1; ram_addr = r_ci; ram_wd = w;
                    n_state = r_mret;
                end else if (rd.chain[IW]) begin
                    n_state = r_mret;
                end else begin
                    n_ci = rd.chain[IW-1:0]; ram_addr = rd.chain[IW-1:0];
                end
            end
            S_MV0: begin
                ram_we = 1'b1; ram_addr = r_mdst; ram_wd = r_mv;
                n_valid[r_mdst] = 1'b1;
                if (r_mv.oprev[IW]) begin
                    n_head = LW'(r_mdst); n_state = S_MV1;
                end else begin
                    n_wa = r_mv.oprev[IW-1:0]; n_wsel = 1'b0; n_wv = LW'(r_mdst);
                    n_ret = S_MV1; n_state = S_RM0;
                end
            end
            S_MV1: begin
                if (r_mv.onext[IW]) begin
                    n_tail = LW'(r_mdst); n_state = r_xret;
                end else begin
                    n_wa = r_mv.onext[IW-1:0]; n_wsel = 1'b1; n_wv = LW'(r_mdst);
                    n_ret = r_xret; n_state = S_RM0;
                end
            end
            S_ER0: begin
                if (r_rec.oprev[IW]) begin
                    n_head = r_rec.onext; n_state = S_ER1;
                end else begin
                    n_wa = r_rec.oprev[IW-1:0]; n_wsel = 1'b0; n_wv = r_rec.onext;
                    n_ret = S_ER1; n_state = S_RM0;
                end
            end
            S_ER1: begin
                if (r_rec.onext[IW]) begin
                    n_tail = r_rec.oprev; n_state = S_ER2;
                end else begin
                    n_wa = r_rec.onext[IW-1:0]; n_wsel = 1'b1; n_wv = r_rec.oprev;
                    n_ret = S_ER2; n_state = S_RM0;
                end
            end
            S_ER2: begin
                if (r_rec.hash[IW-1:0] == r_fidx) begin
                    if (r_rec.chain[IW]) begin
                        n_clr = r_fidx; n_state = S_ERZ;
                    end else begin
                        ram_addr = r_rec.chain[IW-1:0]; n_state = S_ER3;
                    end
                end else begin
                    n_ci = r_rec.hash[IW-1:0]; n_rs = LW'(r_fidx); n_rr = r_rec.chain;
                    n_mret = S_ERZ; n_clr = r_fidx; n_state = S_RD0;
                end
            end
            S_ER3: begin
                // chain successor moves into the freed head slot
                n_mv = rd; n_mdst = r_fidx; n_xret = S_ERZ;
                n_clr = r_rec.chain[IW-1:0]; n_state = S_MV0;
            end
            S_ERZ: begin
                n_valid[r_clr] = 1'b0; n_count = r_count - LW'(1);
                n_st = ST_OK; n_slot = r_fidx; n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1; n_ost = r_st; n_ofound = r_found; n_onkey = r_nkey;
                    n_oslot = SLOT_W'(32'(r_slot)); n_oins = r_ins;
                    n_ocnt = COUNT_W'(32'(r_count));
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_head <= NO_LINK;
            r_tail <= NO_LINK;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_head <= n_head;
            r_tail <= n_tail;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func; r_key <= n_key; r_hash <= n_hash; r_val <= n_val; r_cur <= n_cur;
        r_ci <= n_ci; r_fidx <= n_fidx; r_mdst <= n_mdst; r_wa <= n_wa; r_hd <= n_hd;
        r_fr <= n_fr; r_idx <= n_idx; r_clr <= n_clr; r_first <= n_first; r_hit <= n_hit;
        r_wsel <= n_wsel; r_lin <= n_lin; r_rec <= n_rec; r_mv <= n_mv; r_ret <= n_ret;
        r_mret <= n_mret; r_xret <= n_xret; r_wv <= n_wv; r_rs <= n_rs; r_rr <= n_rr;
        r_h <= n_h; r_p <= n_p; r_n <= n_n; r_st <= n_st; r_found <= n_found;
        r_nkey <= n_nkey; r_slot <= n_slot; r_ins <= n_ins; r_ost <= n_ost;
        r_ofound <= n_ofound; r_onkey <= n_onkey; r_oins <= n_oins; r_oslot <= n_oslot;
        r_ocnt <= n_ocnt;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_ocnt, r_oslot, r_onkey, r_ofound};
    assign m_axis_tuser  = {r_oins, r_ost};

    `OCH_ASSERT(a_count_range, r_count <= NO_LINK, "live count above capacity")
    `OCH_ASSERT(a_empty_list, (r_state == S_IDLE) |-> (r_head[IW] == (r_count == '0)),
        "order list head disagrees with live count")
    `OCH_ASSERT_NEXT(a_insert_count, r_state == S_AP1, r_count == $past(r_count) + LW'(1),
        "insert did not raise live count")
    `OCH_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, r_state != S_IDLE,
        "accepted transaction left sequencer idle")

endmodule
